// File: hw/rtl/swm_pkg.sv
// shared constants and types of the sliding window median filter
package swm_pkg;

  // default sizes
  localparam int unsigned SampleBitsDef = 32;
  localparam int unsigned WindowMaxDef  = 64;

  // width of the window size register
  localparam int unsigned CfgBits = 7;

  // entries in the result queue
  localparam int unsigned OutDepth = 2;

  // flags handed from a cell to its right-hand neighbor
  typedef struct packed {
    logic eq;   // cell holds the evicted value
    logic lw;   // after removal, entry at this place is <= new sample
  } swm_link_t;

endpackage

// File: hw/rtl/swm_cell.sv
// one cell of the sorted chain: holds one window entry in ascending order
module swm_cell #(
  parameter int unsigned SampleBits = swm_pkg::SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic                         full_i,
  input  logic                         valid_i,
  input  logic signed [SampleBits-1:0] sample_i,
  input  logic signed [SampleBits-1:0] old_i,
  input  swm_pkg::swm_link_t           left_link_i,
  input  logic signed [SampleBits-1:0] left_w_i,
  input  logic signed [SampleBits-1:0] right_val_i,
  input  logic                         right_le_i,
  output logic signed [SampleBits-1:0] val_o,
  output logic                         le_o,
  output swm_pkg::swm_link_t           link_o,
  output logic signed [SampleBits-1:0] w_o
);

  logic signed [SampleBits-1:0] val_q, val_d;
  logic le, eq, evict, after, shift;

  // local compares against the new and the evicted sample
  assign le    = valid_i && (val_q <= sample_i);
  assign eq    = valid_i && (val_q == old_i);
  // the evicted entry is the leftmost one equal to the oldest value
  assign evict = full_i && eq && !left_link_i.eq;
  assign after = full_i && valid_i && ((val_q > old_i) || (eq && left_link_i.eq));
  assign shift = evict || after;

  // entry at this place once the oldest one has been removed
  assign w_o       = shift ? right_val_i : val_q;
  assign link_o.lw = shift ? right_le_i : le;
  assign link_o.eq = eq;

  // insertion of the new sample behind all entries <= it
  always_comb begin
    if (link_o.lw) begin
      val_d = w_o;
    end else if (left_link_i.lw) begin
      val_d = sample_i;
    end else begin
      val_d = left_w_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
    end
  end

  assign val_o = val_q;
  assign le_o  = le;

endmodule

// File: hw/rtl/swm_out_fifo.sv
// two-entry result queue between the filter and the receiver
module swm_out_fifo #(
  parameter int unsigned Width = swm_pkg::SampleBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    push_i,
  input  logic [Width-1:0]                        data_i,
  input  logic                                    ready_i,
  output logic                                    valid_o,
  output logic [Width-1:0]                        data_o,
  output logic [$clog2(swm_pkg::OutDepth+1)-1:0]  cnt_o
);

  localparam int unsigned CntBits = $clog2(swm_pkg::OutDepth + 1);

  logic [Width-1:0]   mem_q [swm_pkg::OutDepth];
  logic               wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + CntBits'(1);
    end else if (!push_i && pop) begin
      cnt_d = cnt_q - CntBits'(1);
    end
  end

  // pointers and occupancy count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// File: hw/rtl/sliding_window_median_top.sv
// top level of the sliding window median filter
//
// Running median over the last window_size samples of a signed stream.
// Input channel: sample_valid_i / sample_ready_o with payload sample_i.
// Output channel: median_valid_o / median_ready_i with payload median_o.
// Configuration: cfg_we_i writes cfg_data_i into window_size and restarts
// the fill phase; write only while no item is in flight.
// The first window_size - 1 items after reset or a write give no result;
// every later item gives the lower median of the current window.
// Throughput is one item per cycle while the result queue has room: each
// cell of the sorted chain compares its entry with the new and the evicted
// sample in parallel and takes its next value from itself, a neighbor or
// the input in the same cycle. From acceptance to median_valid_o an item
// passes the chain update, then the median select into the result queue.
// The oldest sample comes from an arrival ring, read ahead into a register.
// Reset empties the window and the result queue and sets window_size to 1.
// A stalled receiver fills the two-entry result queue; sample_ready_o then
// drops until a result is taken.
module sliding_window_median_top #(
  parameter int unsigned WindowMax  = swm_pkg::WindowMaxDef,
  parameter int unsigned SampleBits = swm_pkg::SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [swm_pkg::CfgBits-1:0]  cfg_data_i,
  input  logic                         sample_valid_i,
  output logic                         sample_ready_o,
  input  logic signed [SampleBits-1:0] sample_i,
  output logic                         median_valid_o,
  input  logic                         median_ready_i,
  output logic signed [SampleBits-1:0] median_o
);

  localparam int unsigned IdxBits  = (WindowMax > 1) ? $clog2(WindowMax) : 1;
  localparam int unsigned CntBits  = $clog2(WindowMax + 1);
  localparam int unsigned QCntBits = $clog2(swm_pkg::OutDepth + 1);

  logic [swm_pkg::CfgBits-1:0] window_q;
  logic [CntBits-1:0]          fill_q, fill_d, win_k;
  logic [IdxBits-1:0]          oldest_q, oldest_d, slot, med_idx;
  logic                        acc, full, res_q, res_d;
  logic signed [SampleBits-1:0] old_q;
  logic signed [SampleBits-1:0] ring_q [WindowMax];

  logic signed [SampleBits-1:0] cell_val [WindowMax];
  logic signed [SampleBits-1:0] cell_w   [WindowMax];
  logic                         cell_le  [WindowMax];
  swm_pkg::swm_link_t           cell_link [WindowMax];

  logic [QCntBits-1:0] q_cnt;
  logic [QCntBits:0]   occ;
  logic [SampleBits-1:0] q_data;

  assign acc = sample_valid_i && sample_ready_o;

  // active window length, clamped to 1..WindowMax
  always_comb begin
    if (window_q == '0) begin
      win_k = CntBits'(1);
    end else if (32'(window_q) > WindowMax) begin
      win_k = CntBits'(WindowMax);
    end else begin
      win_k = CntBits'(window_q);
    end
  end

  assign full    = (fill_q == win_k);
  assign slot    = full ? oldest_q : fill_q[IdxBits-1:0];
  assign med_idx = IdxBits'((win_k - CntBits'(1)) >> 1);

  // fill count, oldest slot and pending result
  always_comb begin
    fill_d   = fill_q;
    oldest_d = oldest_q;
    res_d    = 1'b0;
    if (cfg_we_i) begin
      fill_d   = '0;
      oldest_d = '0;
    end else if (acc) begin
      res_d = full || (fill_q + CntBits'(1) == win_k);
      if (full) begin
        if (CntBits'(oldest_q) + CntBits'(1) == win_k) begin
          oldest_d = '0;
        end else begin
          oldest_d = oldest_q + IdxBits'(1);
        end
      end else begin
        fill_d = fill_q + CntBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= swm_pkg::CfgBits'(1);
      fill_q   <= '0;
      oldest_q <= '0;
      res_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_data_i;
      end
      fill_q   <= fill_d;
      oldest_q <= oldest_d;
      res_q    <= res_d;
    end
  end

  // arrival ring, read ahead into old_q at the next oldest slot
  always_ff @(posedge clk_i) begin
    if (acc) begin
      ring_q[slot] <= sample_i;
    end
    if (acc && (slot == oldest_d)) begin
      old_q <= sample_i;
    end else begin
      old_q <= ring_q[oldest_d];
    end
  end

  // sorted chain of cells
  for (genvar i = 0; i < WindowMax; i++) begin : g_cell
    swm_pkg::swm_link_t           left_link;
    logic signed [SampleBits-1:0] left_w, right_val;
    logic                         right_le, cell_valid;

    if (i == 0) begin : g_first
      assign left_link = '{eq: 1'b0, lw: 1'b1};
      assign left_w    = sample_i;
    end else begin : g_mid
      assign left_link = cell_link[i-1];
      assign left_w    = cell_w[i-1];
    end

    if (i == WindowMax - 1) begin : g_last
      assign right_val = '0;
      assign right_le  = 1'b0;
    end else begin : g_body
      assign right_val = cell_val[i+1];
      assign right_le  = cell_le[i+1];
    end

    assign cell_valid = (CntBits'(i) < fill_q);

    swm_cell #(
      .SampleBits(SampleBits)
    ) u_cell (
      .clk_i       (clk_i),
      .en_i        (acc),
      .full_i      (full),
      .valid_i     (cell_valid),
      .sample_i    (sample_i),
      .old_i       (old_q),
      .left_link_i (left_link),
      .left_w_i    (left_w),
      .right_val_i (right_val),
      .right_le_i  (right_le),
      .val_o       (cell_val[i]),
      .le_o        (cell_le[i]),
      .link_o      (cell_link[i]),
      .w_o         (cell_w[i])
    );
  end

  // result queue, fed with the middle cell in the cycle after the update
  swm_out_fifo #(
    .Width(SampleBits)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_q),
    .data_i  (cell_val[med_idx]),
    .ready_i (median_ready_i),
    .valid_o (median_valid_o),
    .data_o  (q_data),
    .cnt_o   (q_cnt)
  );

  assign median_o = q_data;

  // room for one more item counting the result in flight
  assign occ = {1'b0, q_cnt} + (QCntBits + 1)'(res_q);
  assign sample_ready_o = (occ < (QCntBits + 1)'(swm_pkg::OutDepth)) ||
                          ((occ == (QCntBits + 1)'(swm_pkg::OutDepth)) &&
                           median_valid_o && median_ready_i);

endmodule

// File: hw/rtl/swm_checker.sv
// port-level checks of the sliding window median filter and their binding
module swm_checker #(
  parameter int unsigned SampleBits = swm_pkg::SampleBitsDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  sample_valid_i,
  input logic                  sample_ready_o,
  input logic                  median_valid_o,
  input logic                  median_ready_i,
  input logic [SampleBits-1:0] median_o
);

  // a result waits until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    median_valid_o && !median_ready_i |=> median_valid_o)
    else $error("median item dropped while stalled");

  // a stalled result keeps its value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    median_valid_o && !median_ready_i |=> $stable(median_o))
    else $error("median changed while stalled");

  // no result appears without an item accepted just before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !median_valid_o && !$past(sample_valid_i && sample_ready_o) |=> !median_valid_o)
    else $error("median item without an input item");

  // input stalls only while a result is waiting
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_ready_o |-> median_valid_o)
    else $error("input stalled with no result waiting");

endmodule

bind sliding_window_median_top swm_checker #(
  .SampleBits(SampleBits)
) u_swm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .sample_valid_i (sample_valid_i),
  .sample_ready_o (sample_ready_o),
  .median_valid_o (median_valid_o),
  .median_ready_i (median_ready_i),
  .median_o       (median_o)
);
